// ===== src/ibd_pkg.sv =====
// Shared types, constants and the timeout table for the backlight dimmer.
`default_nettype none
package ibd_pkg;

	localparam int KEY_BITS_DEF   = 32;
	localparam int AXIS_BITS_DEF  = 16;
	localparam int AXIS_COUNT_DEF = 4;

	localparam int TIME_W  = 32;
	localparam int THR_W   = 16;
	localparam int SEL_W   = 2;
	localparam int LEVEL_W = 7;
	localparam int OUT_W   = 8;
	localparam int ADDR_W  = 4;
	localparam int PDATA_W = 32;

	localparam logic [LEVEL_W-1:0] WAKE_LEVEL = 7'd100;
	localparam logic [LEVEL_W-1:0] DIM_LEVEL  = 7'd15;
	localparam logic [LEVEL_W-1:0] OFF_LEVEL  = 7'd0;

	localparam logic [THR_W-1:0] THR_RESET = 16'd30;

	typedef enum logic [1:0] {
		REG_DIM_SEL = 2'd0,
		REG_OFF_SEL = 2'd1,
		REG_MOVE_THR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SEL_W-1:0] dim_select;
		logic [SEL_W-1:0] off_select;
		logic [THR_W-1:0] move_threshold;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last;
	} word_t;

	// timeout in ms for a table index; zero disables
	function automatic logic [TIME_W-1:0] timeout_ms(input logic [SEL_W-1:0] sel);
		logic [TIME_W-1:0] t;
		case (sel)
			2'd0:    t = 32'd0;
			2'd1:    t = 32'd30000;
			2'd2:    t = 32'd60000;
			2'd3:    t = 32'd300000;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== src/inactivity_backlight_dimmer.sv =====
// Top level of the inactivity backlight dimmer.
// Each input word is one sample (time, key snapshot, axes). A key change or an
// axis move past the threshold gives one word of 100 and restarts the idle
// time; otherwise the dim and off timeouts give 15 and/or 0, or no word at all.
// A sample is taken every cycle unless one that gives words waits for room in
// the output register. Samples are registered in the input stage; their words
// go on to the output register, which holds two words and drains one per cycle
// while m_tready is high. Configuration must be written over APB while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module inactivity_backlight_dimmer
	import ibd_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int AXIS_BITS  = AXIS_BITS_DEF,
	parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// now_ms, key_snapshot, axis_0 .. axis_N-1, zero pad to bytes
	input  wire logic [((TIME_W+KEY_BITS+AXIS_COUNT*AXIS_BITS+7)/8)*8-1:0] s_tdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// brightness, zero pad bit
	output logic      [OUT_W-1:0]   m_tdata,
	output logic                    m_tlast,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	localparam int DW = (AXIS_BITS + 1 > THR_W) ? AXIS_BITS + 1 : THR_W;

	cfg_t cfg;

	ibd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic                 valid_s1;
	logic [TIME_W-1:0]    now_s1;
	logic [KEY_BITS-1:0]  keys_s1;
	logic [AXIS_BITS-1:0] axes_s1 [AXIS_COUNT];

	// state
	logic [KEY_BITS-1:0]  keys_q;
	logic [AXIS_BITS-1:0] axes_q [AXIS_COUNT];
	logic [TIME_W-1:0]    act_q;

	// result register, two words
	word_t      slot_q [2];
	logic [1:0] cnt_q;

	logic [AXIS_COUNT-1:0] axis_moved;
	logic                  key_chg, moved, dim_hit, off_hit;
	logic [TIME_W-1:0]     dim_t, off_t, off_tab, dim_tab, elapsed;
	logic [1:0]            n_words;
	word_t                 w0, w1;
	logic                  m_fire, out_free, adv;

	assign key_chg = keys_s1 != keys_q;

	for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_axis
		logic signed [AXIS_BITS:0] diff;
		logic        [AXIS_BITS:0] mag;
		assign diff = $signed({axes_q[i][AXIS_BITS-1], axes_q[i]})
			- $signed({axes_s1[i][AXIS_BITS-1], axes_s1[i]});
		assign mag  = diff[AXIS_BITS] ? AXIS_BITS'(1) + ~diff : diff;
		assign axis_moved[i] = DW'(mag) > DW'(cfg.move_threshold);
	end

	assign moved   = |axis_moved;
	assign dim_tab = timeout_ms(cfg.dim_select);
	assign off_tab = timeout_ms(cfg.off_select);
	assign off_t   = off_tab;
	assign dim_t   = (dim_tab > off_tab) ? off_tab : dim_tab;
	assign elapsed = now_s1 - act_q;
	assign dim_hit = (dim_t != '0) && (elapsed > dim_t);
	assign off_hit = (off_t != '0) && (elapsed > off_t);

	always_comb begin
		w0      = '{level: WAKE_LEVEL, last: 1'b1};
		w1      = '{level: OFF_LEVEL, last: 1'b1};
		n_words = 2'd0;
		if (key_chg || moved) begin
			n_words = 2'd1;
		end else if (dim_hit && off_hit) begin
			n_words = 2'd2;
			w0      = '{level: DIM_LEVEL, last: 1'b0};
		end else if (dim_hit) begin
			n_words = 2'd1;
			w0      = '{level: DIM_LEVEL, last: 1'b1};
		end else if (off_hit) begin
			n_words = 2'd1;
			w0      = '{level: OFF_LEVEL, last: 1'b1};
		end
	end

	assign m_fire   = m_tvalid & m_tready;
	assign out_free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_fire);
	assign adv      = valid_s1 && (n_words == 2'd0 || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1  <= s_tdata[TIME_W-1:0];
			keys_s1 <= s_tdata[TIME_W +: KEY_BITS];
			for (int i = 0; i < AXIS_COUNT; i++) begin
				axes_s1[i] <= s_tdata[TIME_W + KEY_BITS + i*AXIS_BITS +: AXIS_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
			act_q  <= '0;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				axes_q[i] <= '0;
			end
		end else if (adv) begin
			if (key_chg) begin
				keys_q <= keys_s1;
				act_q  <= now_s1;
			end else begin
				for (int i = 0; i < AXIS_COUNT; i++) begin
					axes_q[i] <= axes_s1[i];
				end
				if (moved) begin
					act_q <= now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv && n_words != 2'd0) begin
			cnt_q <= n_words;
		end else if (m_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_words != 2'd0) begin
			slot_q[0] <= w0;
			slot_q[1] <= w1;
		end else if (m_fire) begin
			slot_q[0] <= slot_q[1];
		end
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = {1'b0, slot_q[0].level};
	assign m_tlast  = slot_q[0].last;

endmodule
`default_nettype wire

// ===== src/ibd_regs.sv =====
// APB configuration registers of the backlight dimmer.
`default_nettype none
module ibd_regs
	import ibd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_select     <= '0;
			cfg_q.off_select     <= '0;
			cfg_q.move_threshold <= THR_RESET;
		end else if (wr) begin
			case (idx)
				REG_DIM_SEL:  cfg_q.dim_select     <= pwdata[SEL_W-1:0];
				REG_OFF_SEL:  cfg_q.off_select     <= pwdata[SEL_W-1:0];
				REG_MOVE_THR: cfg_q.move_threshold <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DIM_SEL:  prdata = {{(PDATA_W-SEL_W){1'b0}}, cfg_q.dim_select};
			REG_OFF_SEL:  prdata = {{(PDATA_W-SEL_W){1'b0}}, cfg_q.off_select};
			REG_MOVE_THR: prdata = {{(PDATA_W-THR_W){1'b0}}, cfg_q.move_threshold};
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/ibd_checker.sv =====
// Port-level checks of the backlight dimmer output stream, bound to the top level.
`default_nettype none
module ibd_checker
	import ibd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic             m_tlast
);

	logic [LEVEL_W-1:0] lvl;
	assign lvl = m_tdata[LEVEL_W-1:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_W-1] == 1'b0
			&& (lvl == WAKE_LEVEL || lvl == DIM_LEVEL || lvl == OFF_LEVEL))
		else $error("illegal brightness");

	a_wake_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (lvl == WAKE_LEVEL || lvl == OFF_LEVEL) |-> m_tlast)
		else $error("wake or off word not last of its sample");

	a_dim_then_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && lvl == DIM_LEVEL && !m_tlast
			|=> m_tvalid && m_tdata[LEVEL_W-1:0] == OFF_LEVEL && m_tlast)
		else $error("dim word not followed by off word");

endmodule

bind inactivity_backlight_dimmer ibd_checker u_ibd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ===== test/inactivity_backlight_dimmer_tb.sv =====
// Self-checking bench for the inactivity backlight dimmer: a shadow of its idle logic predicts the brightness words.
module inactivity_backlight_dimmer_tb;
	import ibd_pkg::*;

	localparam int SAMPLE_W = ((TIME_W + KEY_BITS_DEF + AXIS_COUNT_DEF*AXIS_BITS_DEF + 7)/8)*8;
	localparam int IDLE_LIMIT_CYCLES = 2000;
	localparam int PHASE_SAMPLES = 133;

	localparam logic [ADDR_W-1:0] ADDR_DIM   = {REG_DIM_SEL, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_OFF   = {REG_OFF_SEL, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_THR   = {REG_MOVE_THR, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_SPARE = 4'd12;

	// idle timeouts in ms, indexed by the select registers
	localparam logic [3:0][TIME_W-1:0] IDLE_LIMIT_MS =
		{32'd300000, 32'd60000, 32'd30000, 32'd0};

	localparam logic [15:0] AX_MIN = 16'h8000;
	localparam logic [15:0] AX_MAX = 16'h7FFF;

	typedef logic [AXIS_COUNT_DEF-1:0][AXIS_BITS_DEF-1:0] axes_t;

	typedef struct packed {
		logic [KEY_BITS_DEF-1:0] keys;
		axes_t                   axes;
		logic [TIME_W-1:0]       active_ms;
		logic [SEL_W-1:0]        dim_sel;
		logic [SEL_W-1:0]        off_sel;
		logic [THR_W-1:0]        thr;
	} panel_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	wire                 s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;
	wire                 m_tvalid;
	logic                m_tready = 1'b0;
	wire  [OUT_W-1:0]    m_tdata;
	wire                 m_tlast;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	wire  [PDATA_W-1:0]  prdata;
	wire                 pready;

	logic [SAMPLE_W-1:0] pending_samples[$];
	word_t               expected_brightness[$];
	panel_t              tracked = '0;
	panel_t              planned = '0;
	logic [TIME_W-1:0]   gen_now = '0;
	int                  send_gap_pct = 18;
	int                  recv_stall_pct = 65;
	int                  mismatches = 0;
	int                  idle_cycles = 0;

	inactivity_backlight_dimmer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one sample through the idle logic; returns the number of brightness words
	function automatic int advance_backlight(inout panel_t p, input logic [SAMPLE_W-1:0] w,
			output logic [LEVEL_W-1:0] first, output logic [LEVEL_W-1:0] second);
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] dim_ms;
		logic [TIME_W-1:0] off_ms;
		axes_t             ax;
		logic              moved;
		int                a;
		int                b;
		int                n;
		now = w[TIME_W-1:0];
		ax = w[TIME_W+KEY_BITS_DEF +: AXIS_COUNT_DEF*AXIS_BITS_DEF];
		first = OFF_LEVEL;
		second = OFF_LEVEL;
		n = 0;
		if (w[TIME_W +: KEY_BITS_DEF] != p.keys) begin
			p.keys = w[TIME_W +: KEY_BITS_DEF];
			p.active_ms = now;
			first = WAKE_LEVEL;
			return 1;
		end
		moved = 1'b0;
		for (int i = 0; i < AXIS_COUNT_DEF; i++) begin
			a = $signed(p.axes[i]);
			b = $signed(ax[i]);
			if (a - b > int'(p.thr) || b - a > int'(p.thr))
				moved = 1'b1;
		end
		if (moved) begin
			p.active_ms = now;
			first = WAKE_LEVEL;
			n = 1;
		end
		p.axes = ax;
		dim_ms = IDLE_LIMIT_MS[p.dim_sel];
		off_ms = IDLE_LIMIT_MS[p.off_sel];
		if (dim_ms > off_ms)
			dim_ms = off_ms;
		elapsed = now - p.active_ms;
		if (dim_ms != 0 && elapsed > dim_ms) begin
			if (n == 0)
				first = DIM_LEVEL;
			else
				second = DIM_LEVEL;
			n++;
		end
		if (off_ms != 0 && elapsed > off_ms) begin
			if (n == 0)
				first = OFF_LEVEL;
			else
				second = OFF_LEVEL;
			n++;
		end
		return n;
	endfunction

	function automatic logic [AXIS_BITS_DEF-1:0] axis_clamp(input int v);
		if (v > 32767)
			return AX_MAX;
		if (v < -32768)
			return AX_MIN;
		return v[AXIS_BITS_DEF-1:0];
	endfunction

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (addr)
			ADDR_DIM: begin
				tracked.dim_sel = data[SEL_W-1:0];
				planned.dim_sel = data[SEL_W-1:0];
			end
			ADDR_OFF: begin
				tracked.off_sel = data[SEL_W-1:0];
				planned.off_sel = data[SEL_W-1:0];
			end
			ADDR_THR: begin
				tracked.thr = data[THR_W-1:0];
				planned.thr = data[THR_W-1:0];
			end
			default: ;
		endcase
	endtask

	task automatic send(input logic [TIME_W-1:0] now, input logic [KEY_BITS_DEF-1:0] keys,
			input axes_t ax);
		logic [SAMPLE_W-1:0] w;
		logic [LEVEL_W-1:0]  l0;
		logic [LEVEL_W-1:0]  l1;
		int                  n;
		w = '0;
		w[TIME_W-1:0] = now;
		w[TIME_W +: KEY_BITS_DEF] = keys;
		w[TIME_W+KEY_BITS_DEF +: AXIS_COUNT_DEF*AXIS_BITS_DEF] = ax;
		n = advance_backlight(planned, w, l0, l1);
		gen_now = now;
		pending_samples.push_back(w);
	endtask

	// wait for all samples taken and all words back, then let the pipe drain
	task automatic settle();
		while (pending_samples.size() != 0 || s_tvalid || expected_brightness.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_samples.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		word_t              exp_w;
		logic [LEVEL_W-1:0] l0;
		logic [LEVEL_W-1:0] l1;
		int                 n;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_brightness.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: level %0d last %0b", m_tdata, m_tlast);
					mismatches++;
				end else begin
					exp_w = expected_brightness.pop_front();
					if (m_tdata !== {1'b0, exp_w.level} || m_tlast !== exp_w.last) begin
						if (mismatches < 10)
							$display("word: expected level %0d last %0b, got %0d last %0b",
								exp_w.level, exp_w.last, m_tdata, m_tlast);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				n = advance_backlight(tracked, s_tdata, l0, l1);
				if (n >= 1) begin
					exp_w.level = l0;
					exp_w.last = (n == 1);
					expected_brightness.push_back(exp_w);
				end
				if (n == 2) begin
					exp_w.level = l1;
					exp_w.last = 1'b1;
					expected_brightness.push_back(exp_w);
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT_CYCLES) begin
				$display("inactivity_backlight_dimmer: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int                      stage;
		int                      kind;
		int                      delta;
		int                      base;
		logic [TIME_W-1:0]       now;
		logic [KEY_BITS_DEF-1:0] keys;
		axes_t                   ax;
		logic [THR_W-1:0]        thr;
		tracked.thr = THR_RESET;
		planned.thr = THR_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: timeouts off, threshold 30
		send(32'd0, 32'd0, '0);
		send(32'd5, 32'd0, {16'h0000, 16'h0000, 16'h0000, 16'h001F});
		settle();
		apb_write(ADDR_DIM, 32'hFFFF_FFF1);
		apb_write(ADDR_OFF, 32'hABCD_0006);
		apb_write(ADDR_THR, 32'h5A5A_001E);
		apb_write(ADDR_SPARE, 32'hFFFF_FFFF);

		// dim 30 s, off 60 s: exact and one-past timeouts
		ax = {16'h0000, 16'h0000, 16'h0000, 16'h001F};
		send(32'd1000, 32'hFFFF_FFFF, ax);
		send(32'd31000, 32'hFFFF_FFFF, ax);
		send(32'd31001, 32'hFFFF_FFFF, ax);
		send(32'd61000, 32'hFFFF_FFFF, ax);
		send(32'd61001, 32'hFFFF_FFFF, ax);
		// axis change equal to the threshold is not a move
		send(32'd61002, 32'hFFFF_FFFF, {16'h0000, 16'h0000, 16'h001E, 16'h001F});
		send(32'd61003, 32'hFFFF_FFFF, {16'h0000, 16'h0000, 16'h001E, 16'h0000});
		send(32'd100000, 32'hFFFF_FFFF, {16'h0000, AX_MIN, 16'h001E, 16'h0000});
		ax = {16'h0000, AX_MAX, 16'h001E, 16'h0000};
		send(32'd100001, 32'hFFFF_FFFF, ax);
		// key change: axes neither compared nor stored
		send(32'hFFFF_FF00, 32'h0000_0000, {AX_MAX, AX_MIN, AX_MAX, AX_MIN});
		// elapsed time across the 32-bit wrap
		send(32'h0000_F000, 32'h0000_0000, ax);
		send(32'h7FFF_FFFF, 32'h8000_0001, ax);
		send(32'hFFFF_FFFF, 32'h8000_0001, ax);
		settle();

		// dim table entry above off: capped to the off timeout
		apb_write(ADDR_DIM, 32'd3);
		apb_write(ADDR_OFF, 32'd1);
		send(32'd1000, 32'h0000_0002, ax);
		send(32'd31000, 32'h0000_0002, ax);
		send(32'd31001, 32'h0000_0002, ax);
		settle();

		apb_write(ADDR_THR, 32'h0000_FFFF);
		apb_write(ADDR_DIM, 32'd0);
		apb_write(ADDR_OFF, 32'd3);
		ax = {AX_MAX, AX_MIN, AX_MAX, AX_MIN};
		send(32'd31002, 32'h0000_0002, ax);
		send(32'd301000, 32'h0000_0002, ax);
		send(32'd301001, 32'h0000_0002, ax);
		settle();

		apb_write(ADDR_THR, 32'hFFFF_0000);
		send(32'd301002, 32'h0000_0002, {AX_MAX, AX_MIN, AX_MAX, 16'h8001});

		for (stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					send_gap_pct = 18;
					recv_stall_pct = 65;
				end
				1: begin
					send_gap_pct = 65;
					recv_stall_pct = 18;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int k = 0; k < 4; k++) begin
				settle();
				case (k)
					0: thr = 16'd0;
					1: thr = 16'hFFFF;
					2: thr = 16'($urandom_range(200, 0));
					default: thr = 16'($urandom());
				endcase
				apb_write(ADDR_DIM, $urandom());
				apb_write(ADDR_OFF, $urandom());
				apb_write(ADDR_THR, {16'($urandom()), thr});
				if ($urandom_range(3, 0) == 0)
					apb_write(ADDR_SPARE, $urandom());
				for (int j = 0; j < PHASE_SAMPLES; j++) begin
					kind = $urandom_range(99, 0);
					now = gen_now + $urandom_range(2000, 0);
					keys = planned.keys;
					ax = planned.axes;
					if (kind < 60) begin
						// quiet sample: keys held, axes jitter within the threshold
						case ($urandom_range(4, 0))
							1: now = gen_now + $urandom_range(40000, 0);
							2: now = planned.active_ms + IDLE_LIMIT_MS[$urandom_range(3, 1)]
								+ $urandom_range(2, 0) - 1;
							3: now = gen_now + $urandom_range(400000, 0);
							4: now = 32'hFFFF_FFFF - $urandom_range(100000, 0);
							default: ;
						endcase
						for (int i = 0; i < AXIS_COUNT_DEF; i++) begin
							delta = $urandom_range(planned.thr, 0);
							if ($urandom_range(1, 0))
								delta = -delta;
							base = $signed(ax[i]);
							ax[i] = axis_clamp(base + delta);
						end
					end else if (kind < 75) begin
						base = $urandom_range(AXIS_COUNT_DEF - 1, 0);
						delta = int'(planned.thr) + 1 + $urandom_range(40, 0);
						if ($signed(ax[base]) + delta > 32767)
							delta = -delta;
						ax[base] = axis_clamp($signed(ax[base]) + delta);
					end else if (kind < 88) begin
						if ($urandom_range(1, 0))
							keys = planned.keys ^ (32'd1 << $urandom_range(31, 0));
						else
							keys = $urandom();
					end else begin
						now = $urandom();
						if ($urandom_range(3, 0) != 0)
							keys = $urandom();
						ax = {$urandom(), $urandom()};
					end
					send(now, keys, ax);
				end
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_brightness.size() == 0)
			$display("inactivity_backlight_dimmer: match");
		else
			$display("inactivity_backlight_dimmer: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
src/ibd_pkg.sv
src/ibd_regs.sv
src/inactivity_backlight_dimmer.sv
src/ibd_checker.sv
test/inactivity_backlight_dimmer_tb.sv
